[src/rtihls_pkg.sv]
// Shared types, constants and the arctangent table for the RGB to IHLS converter.
package rtihls_pkg;

    localparam int XW    = 28;   // CORDIC x/y width, covers gain of about 1.65
    localparam int ZW    = 20;   // angle width, radians Q16
    localparam int SUMW  = 18;   // luminance weighted sum width
    localparam int STEPS = 17;   // vectoring iterations

    localparam logic signed [ZW-1:0] ANG_PI     = 20'sd205887;
    localparam logic signed [ZW-1:0] ANG_TWO_PI = 20'sd411775;
    localparam logic [16:0]          SQRT3_Q16  = 17'd113512;

    localparam logic [9:0]  LUM_R   = 10'd210;
    localparam logic [9:0]  LUM_G   = 10'd715;
    localparam logic [9:0]  LUM_B   = 10'd72;
    localparam logic [9:0]  LUM_DIV = 10'd1000;
    // floor(2^28 / 1000) and floor(2^40 / 411775)
    localparam logic [18:0] LUM_RECIP = 19'd268435;
    localparam logic [21:0] HUE_RECIP = 22'd2670175;

    localparam logic [7:0] HUE_HALF = 8'd127;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 ys_zero;
        logic                 ys_pos;
        logic                 xs_neg;
        logic [7:0]           sat;
        logic [SUMW-1:0]      lum_sum;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 20'sd51472;
            1:  v = 20'sd30386;
            2:  v = 20'sd16055;
            3:  v = 20'sd8150;
            4:  v = 20'sd4091;
            5:  v = 20'sd2047;
            6:  v = 20'sd1024;
            7:  v = 20'sd512;
            8:  v = 20'sd256;
            9:  v = 20'sd128;
            10: v = 20'sd64;
            11: v = 20'sd32;
            12: v = 20'sd16;
            13: v = 20'sd8;
            14: v = 20'sd4;
            15: v = 20'sd2;
            16: v = 20'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/rtihls_front.sv]
// Input stage: chromatic vector set-up, saturation and luminance sum.
module rtihls_front import rtihls_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       vld_in,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       vld_out,
    output cordic_t    data_out
);

    logic signed [10:0]   xs;
    logic signed [9:0]    ys;
    logic signed [XW-1:0] x_mul;
    logic signed [XW-1:0] y_mul;
    logic signed [XW-1:0] k_ext;
    logic [7:0]           mx;
    logic [7:0]           mn;
    logic                 vld_reg;
    cordic_t              data_reg;
    cordic_t              data_next;

    always_comb
    begin
        xs    = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
                - $signed({3'b000, blue});
        ys    = $signed({2'b00, green}) - $signed({2'b00, blue});
        k_ext = $signed({{(XW-17){1'b0}}, SQRT3_Q16});
        x_mul = XW'(xs) <<< 16;
        y_mul = XW'(ys) * k_ext;

        mx = red;
        mn = red;
        if (green > mx) mx = green;
        if (blue  > mx) mx = blue;
        if (green < mn) mn = green;
        if (blue  < mn) mn = blue;

        data_next.xs_neg  = xs[10];
        data_next.ys_zero = (ys == '0);
        data_next.ys_pos  = !ys[9] && (ys != '0);
        // left half-plane: rotate by pi first
        data_next.x  = xs[10] ? -x_mul : x_mul;
        data_next.y  = xs[10] ? -y_mul : y_mul;
        data_next.z  = xs[10] ? ANG_PI : '0;
        data_next.sat = mx - mn;
        data_next.lum_sum = SUMW'(red) * SUMW'(LUM_R) + SUMW'(green) * SUMW'(LUM_G)
                          + SUMW'(blue) * SUMW'(LUM_B);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign vld_out  = vld_reg;
    assign data_out = data_reg;

endmodule

[src/rtihls_cordic_stage.sv]
// One registered CORDIC vectoring iteration.
module rtihls_cordic_stage import rtihls_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  logic    vld_in,
    input  cordic_t data_in,
    output logic    vld_out,
    output cordic_t data_out
);

    logic    vld_reg;
    cordic_t data_reg;
    cordic_t data_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    always_comb
    begin
        data_next = data_in;
        dx = data_in.y >>> IDX;
        dy = data_in.x >>> IDX;
        if (!data_in.y[XW-1])
        begin
            data_next.x = data_in.x + dx;
            data_next.y = data_in.y - dy;
            data_next.z = data_in.z + atan_q16(IDX);
        end
        else
        begin
            data_next.x = data_in.x - dx;
            data_next.y = data_in.y + dy;
            data_next.z = data_in.z - atan_q16(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign vld_out  = vld_reg;
    assign data_out = data_reg;

endmodule

[src/rtihls_back.sv]
// Output stages: angle fold-up, scaling to 8 bits and the luminance divide.
module rtihls_back import rtihls_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       vld_in,
    input  cordic_t    data_in,
    output logic       vld_out,
    output logic [7:0] sat_out,
    output logic [7:0] lum_out,
    output logic [7:0] hue_out
);

    // stage 1
    logic signed [ZW-1:0] zc;
    logic [18:0]          zu;
    logic [36:0]          lprod;
    logic                 vld1_reg;
    logic [26:0]          p1_reg;
    logic [SUMW-1:0]      sum1_reg;
    logic [7:0]           lq1_reg;
    logic [7:0]           sat1_reg;
    logic [1:0]           spec1_reg;   // {ys_zero, xs_neg}

    // stage 2
    logic [48:0]          hprod;
    logic [SUMW-1:0]      lrem;
    logic                 vld2_reg;
    logic [26:0]          p2_reg;
    logic [7:0]           hq2_reg;
    logic [7:0]           lum2_reg;
    logic [7:0]           sat2_reg;
    logic [1:0]           spec2_reg;

    // stage 3
    logic [26:0]          hrem;
    logic [8:0]           hq_fix;
    logic [7:0]           hue_next;
    logic                 vld3_reg;
    logic [7:0]           hue3_reg;
    logic [7:0]           lum3_reg;
    logic [7:0]           sat3_reg;

    always_comb
    begin
        zc = data_in.z;
        if (data_in.ys_pos)
        begin
            if (zc < 0)      zc = '0;
            if (zc > ANG_PI) zc = ANG_PI;
        end
        else
        begin
            // lower half: keep angle in [pi, 2pi), zero wraps to just below 2pi
            if (!data_in.xs_neg)
            begin
                if (zc >= 0) zc = -20'sd1;
                zc = zc + ANG_TWO_PI;
            end
            if (zc < ANG_PI)             zc = ANG_PI;
            if (zc > ANG_TWO_PI - 20'sd1) zc = ANG_TWO_PI - 20'sd1;
        end
        zu    = zc[18:0];
        lprod = 37'(data_in.lum_sum) * 37'(LUM_RECIP);
    end

    always_comb
    begin
        hprod = 49'(p1_reg) * 49'(HUE_RECIP);
        lrem  = sum1_reg - SUMW'(lq1_reg) * SUMW'(LUM_DIV);
    end

    always_comb
    begin
        hrem   = p2_reg - 27'(hq2_reg) * 27'(ANG_TWO_PI);
        hq_fix = {1'b0, hq2_reg} + ((hrem >= 27'(ANG_TWO_PI)) ? 9'd1 : 9'd0);
        priority if (spec2_reg[1])
            hue_next = spec2_reg[0] ? HUE_HALF : 8'd0;
        else if (hq_fix[8])
            hue_next = 8'hff;
        else
            hue_next = hq_fix[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= vld_in;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg    <= (27'(zu) << 8) - 27'(zu);
            sum1_reg  <= data_in.lum_sum;
            lq1_reg   <= lprod[35:28];
            sat1_reg  <= data_in.sat;
            spec1_reg <= {data_in.ys_zero, data_in.xs_neg};

            p2_reg    <= p1_reg;
            hq2_reg   <= hprod[47:40];
            lum2_reg  <= lq1_reg + ((lrem >= SUMW'(LUM_DIV)) ? 8'd1 : 8'd0);
            sat2_reg  <= sat1_reg;
            spec2_reg <= spec1_reg;

            hue3_reg  <= hue_next;
            lum3_reg  <= lum2_reg;
            sat3_reg  <= sat2_reg;
        end
    end

    assign vld_out = vld3_reg;
    assign sat_out = sat3_reg;
    assign lum_out = lum3_reg;
    assign hue_out = hue3_reg;

endmodule

[src/rgb_to_ihls_pixel_converter_unit.sv]
// RGB to IHLS converter: front stage, 17 CORDIC stages, 3 output stages.
// Pipeline: 21 register stages between the input accept edge and a valid result.
// Throughput: one item per cycle; the whole pipeline holds while the output stalls.
// in_ready follows out_ready combinationally through the shared advance enable.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
module rgb_to_ihls_pixel_converter_unit import rtihls_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] saturation,
    output logic [7:0] luminance,
    output logic [7:0] hue
);

    logic    adv;
    logic    vld_s [STEPS+1];
    cordic_t dat_s [STEPS+1];

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    rtihls_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (in_valid),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .vld_out  (vld_s[0]),
        .data_out (dat_s[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cordic
        rtihls_cordic_stage #(.IDX(i)) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .vld_in   (vld_s[i]),
            .data_in  (dat_s[i]),
            .vld_out  (vld_s[i+1]),
            .data_out (dat_s[i+1])
        );
    end

    rtihls_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (vld_s[STEPS]),
        .data_in (dat_s[STEPS]),
        .vld_out (out_valid),
        .sat_out (saturation),
        .lum_out (luminance),
        .hue_out (hue)
    );

    // grey pixel gives no hue
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (saturation == 8'd0) |-> (hue == 8'd0))
        else $error("grey item with non-zero hue");

    a_lum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (luminance != 8'hff))
        else $error("luminance out of range");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

endmodule

[tb/tb_rgb_to_ihls_pixel_converter_unit.sv]
// Testbench for the RGB to IHLS pixel converter: directed and random pixels against a predictor.
module tb_rgb_to_ihls_pixel_converter_unit;

    localparam int ANG_PI_Q16  = 205887;
    localparam int ANG_2PI_Q16 = 411775;
    localparam int SQRT3_FX    = 113512;

    typedef struct packed {
        logic [7:0] sat;
        logic [7:0] lum;
        logic [7:0] hue;
    } ihls_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] saturation;
    logic [7:0] luminance;
    logic [7:0] hue;

    ihls_t pending_pixels[$];
    int    n_errors;
    int    n_results;
    int    n_sent;
    bit    quiet_tail;

    rgb_to_ihls_pixel_converter_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .saturation (saturation),
        .luminance  (luminance),
        .hue        (hue)
    );

    function automatic longint floor_shift(longint v, int k);
        if (v < 0)
            return ~((~v) >>> k);
        return v >>> k;
    endfunction

    function automatic int atan_step(int i);
        int tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
        return tab[i];
    endfunction

    function automatic logic [7:0] hue_angle(int r, int g, int b);
        longint xs, ys, x, y, z, dx, dy, h;
        xs = 2 * r - g - b;
        ys = g - b;
        if (ys == 0)
            return (xs < 0) ? 8'd127 : 8'd0;
        x = xs * 65536;
        y = ys * SQRT3_FX;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = ANG_PI_Q16;
        end
        for (int i = 0; i < 17; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        if (ys > 0) begin
            if (z < 0) z = 0;
            if (z > ANG_PI_Q16) z = ANG_PI_Q16;
        end else begin
            // blue above green: keep away from the wrap to zero
            if (xs >= 0) begin
                if (z >= 0) z = -1;
                z += ANG_2PI_Q16;
            end
            if (z < ANG_PI_Q16) z = ANG_PI_Q16;
            if (z > ANG_2PI_Q16 - 1) z = ANG_2PI_Q16 - 1;
        end
        h = (z * 255) / ANG_2PI_Q16;
        if (h > 255) h = 255;
        return h[7:0];
    endfunction

    function automatic ihls_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        ihls_t res;
        int mx, mn;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        res.sat = 8'(mx - mn);
        res.lum = 8'((210 * int'(r) + 715 * int'(g) + 72 * int'(b)) / 1000);
        res.hue = hue_angle(r, g, b);
        return res;
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("%0t: timeout, %0d items still awaited", $time, pending_pixels.size());
        $display("status: fail");
        $finish;
    end

    // output side: random stall bursts, then check each item
    initial begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 14);
                out_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
                @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        ihls_t want;
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (pending_pixels.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected item sat=%0d lum=%0d hue=%0d",
                         $time, saturation, luminance, hue);
            end else begin
                want = pending_pixels.pop_front();
                if (saturation !== want.sat) begin
                    n_errors++;
                    $display("%0t: saturation expected %0d actual %0d",
                             $time, want.sat, saturation);
                end
                if (luminance !== want.lum) begin
                    n_errors++;
                    $display("%0t: luminance expected %0d actual %0d",
                             $time, want.lum, luminance);
                end
                if (hue !== want.hue) begin
                    n_errors++;
                    $display("%0t: hue expected %0d actual %0d", $time, want.hue, hue);
                end
            end
        end
    end

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_pixels.push_back(convert_pixel(r, g, b));
        n_sent++;
    endtask

    task automatic test_directed_pixels();
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd77, 8'd77, 8'd77);
        send_pixel(8'd200, 8'd10, 8'd10);       // green equals blue, red above
        send_pixel(8'd5, 8'd90, 8'd90);         // green equals blue, red below
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);         // blue just above green, near the wrap
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd128, 8'd0, 8'd1);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd170, 8'd85, 8'd255);
        send_pixel(8'd85, 8'd170, 8'd0);
    endtask

    task automatic test_random_pixels(int count);
        logic [7:0] r, g, b;
        for (int i = 0; i < count; i++) begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            case ($urandom_range(0, 7))
                0: begin g = r; b = r; end
                1: b = g;
                2: b = g + 8'd1;
                3: g = b + 8'd1;
                default: ;
            endcase
            send_pixel(r, g, b);
        end
    endtask

    task automatic test_back_to_back(int count);
        quiet_tail = 1'b1;
        test_random_pixels(count);
    endtask

    initial begin
        int waited;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        red        = '0;
        green      = '0;
        blue       = '0;
        n_errors   = 0;
        n_results  = 0;
        n_sent     = 0;
        quiet_tail = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_pixels();
        test_random_pixels(1500);
        test_back_to_back(200);
        in_valid <= 1'b0;

        waited = 0;
        while (pending_pixels.size() != 0 && waited < 100000) begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);

        $display("%0d pixels sent, %0d results checked (grey, equal green/blue, wrap cases)",
                 n_sent, n_results);
        if (n_errors == 0 && pending_pixels.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[rgb_to_ihls_pixel_converter_unit.f]
src/rtihls_pkg.sv
src/rtihls_front.sv
src/rtihls_cordic_stage.sv
src/rtihls_back.sv
src/rgb_to_ihls_pixel_converter_unit.sv
tb/tb_rgb_to_ihls_pixel_converter_unit.sv
